FILE: rtl/hcgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcgr_pkg
// Shared types and character constants of the hex color grayscale rewriter.
// ----------------------------------------------------------------------------
package hcgr_pkg;

	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_SEMI = 8'h3b;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_word_t;

	typedef enum logic {
		TOK_PASS = 1'b0,
		TOK_GRAY = 1'b1
	} tok_kind_t;

	// one classified unit of work: a literal byte or a color given as r, g, b
	typedef struct packed {
		tok_kind_t   kind;
		logic        last;
		logic [23:0] data;
	} tok_t;

endpackage

FILE: rtl/hcgr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcgr_front
// Lookahead window: takes input words, matches colors at a leading '#' and
// pushes literal or color tokens into the queue, one token per cycle while it holds work and the queue is not full.
// ----------------------------------------------------------------------------
module hcgr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hcgr_pkg::in_word_t in_word,
	output logic              push,
	output hcgr_pkg::tok_t    push_tok,
	input  logic              q_full
);

	localparam int unsigned WIN = 8;

	logic [7:0] win_q [WIN];
	logic [3:0] cnt_q;
	logic       flush_q;

	logic       front_hash;
	logic       busy;
	logic       in_fire;
	logic [3:0] drop;
	logic [3:0] new_cnt;
	logic [6:1] h_ok;
	logic [3:0] h_val [7];
	logic       short_sel;
	logic       long_sel;

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	assign front_hash = (win_q[0] == hcgr_pkg::CHAR_HASH);
	// a '#' at the front waits for a full window or for the end of the stream
	assign busy       = (cnt_q != 4'd0) && (!front_hash || cnt_q == 4'd8 || flush_q);
	assign in_stall   = busy;
	assign in_fire    = in_valid && !busy;

	always_comb begin
		h_val[0] = 4'd0;
		for (int i = 1; i < 7; i++) begin
			{h_ok[i], h_val[i]} = hex_decode(win_q[i]);
		end
	end

	assign short_sel = (cnt_q >= 4'd5) && (win_q[4] == hcgr_pkg::CHAR_SEMI);
	assign long_sel  = (cnt_q == 4'd8) && (win_q[7] == hcgr_pkg::CHAR_SEMI);

	always_comb begin
		push          = 1'b0;
		drop          = 4'd0;
		push_tok.kind = hcgr_pkg::TOK_PASS;
		push_tok.data = {16'd0, win_q[0]};
		if (busy && !q_full) begin
			push = 1'b1;
			drop = 4'd1;
			if (front_hash) begin
				if (short_sel) begin
					if (h_ok[1] && h_ok[2] && h_ok[3]) begin
						push_tok.kind = hcgr_pkg::TOK_GRAY;
						push_tok.data = {h_val[1], h_val[1], h_val[2], h_val[2],
							h_val[3], h_val[3]};
						drop = 4'd5;
					end
				end else if (long_sel && (&h_ok)) begin
					push_tok.kind = hcgr_pkg::TOK_GRAY;
					push_tok.data = {h_val[1], h_val[2], h_val[3], h_val[4],
						h_val[5], h_val[6]};
					drop = 4'd8;
				end
			end
		end
		new_cnt       = (drop >= cnt_q) ? 4'd0 : cnt_q - drop;
		push_tok.last = flush_q && (new_cnt == 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 4'd0;
			flush_q <= 1'b0;
		end else if (in_fire) begin
			cnt_q   <= cnt_q + 4'd1;
			flush_q <= in_word.in_last;
		end else if (push) begin
			cnt_q <= new_cnt;
			if (new_cnt == 4'd0) begin
				flush_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			win_q[cnt_q[2:0]] <= in_word.in_byte;
		end else if (push) begin
			for (int i = 0; i < WIN; i++) begin
				if (drop == 4'd1 && i + 1 < WIN) begin
					win_q[i] <= win_q[i + 1];
				end else if (drop == 4'd5 && i + 5 < WIN) begin
					win_q[i] <= win_q[i + 5];
				end
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd8)
		else $error("window count out of range");

	a_idle_front: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall && cnt_q != 4'd0) |-> (front_hash && !flush_q))
		else $error("window idle with work at the front");

	a_flush_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_tok.last) |=> (cnt_q == 4'd0 && !flush_q))
		else $error("last token pushed but window not empty");

endmodule

FILE: rtl/hcgr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcgr_fifo
// Four-entry token queue between the window and the output side.
// ----------------------------------------------------------------------------
module hcgr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hcgr_pkg::tok_t push_tok,
	output logic           full,
	output logic           q_valid,
	output hcgr_pkg::tok_t q_tok,
	input  logic           pop
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned AW    = $clog2(DEPTH);

	hcgr_pkg::tok_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;

	assign full    = (count_q == (AW + 1)'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !q_valid))
		else $error("queue overflow or underflow");

endmodule

FILE: rtl/hcgr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcgr_back
// Output side: luma sum, reciprocal divide by 1000, then expands a color
// token into '#', three digit pairs and ';', one word per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module hcgr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  hcgr_pkg::tok_t      q_tok,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output hcgr_pkg::out_word_t out_word
);

	localparam logic [17:0] W_R    = 18'd299;
	localparam logic [17:0] W_G    = 18'd587;
	localparam logic [17:0] W_B    = 18'd114;
	localparam logic [17:0] ROUND  = 18'd500;
	// ceil(2^28 / 1000): exact floor division for sums below 2^18
	localparam logic [18:0] RECIP  = 19'd268436;

	logic                valid_s1;
	hcgr_pkg::tok_kind_t kind_s1;
	logic                last_s1;
	logic [7:0]          byte_s1;
	logic [17:0]         sum_s1;

	logic                valid_s2;
	hcgr_pkg::tok_kind_t kind_s2;
	logic                last_s2;
	logic [7:0]          byte_s2;

	logic                em_valid_q;
	hcgr_pkg::tok_kind_t em_kind_q;
	logic                em_last_q;
	logic [7:0]          em_byte_q;
	logic [2:0]          idx_q;

	logic        em_fire;
	logic        em_done;
	logic        em_free;
	logic        load_em;
	logic        s2_free;
	logic        adv_s2;
	logic        s1_free;
	logic [17:0] sum_d;
	logic [36:0] prod;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
	endfunction

	assign em_fire = em_valid_q && !out_stall;
	assign em_done = em_fire && (em_kind_q == hcgr_pkg::TOK_PASS || idx_q == 3'd7);
	assign em_free = !em_valid_q || em_done;
	assign load_em = valid_s2 && em_free;
	assign s2_free = !valid_s2 || load_em;
	assign adv_s2  = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || s2_free;
	assign pop     = q_valid && s1_free;

	assign sum_d = W_R * {10'd0, q_tok.data[23:16]} + W_G * {10'd0, q_tok.data[15:8]}
		+ W_B * {10'd0, q_tok.data[7:0]} + ROUND;
	assign prod  = {19'd0, sum_s1} * {18'd0, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			em_valid_q <= 1'b0;
			idx_q      <= 3'd0;
		end else begin
			if (s1_free) begin
				valid_s1 <= q_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (em_free) begin
				em_valid_q <= valid_s2;
				idx_q      <= 3'd0;
			end else if (em_fire) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= q_tok.kind;
			last_s1 <= q_tok.last;
			byte_s1 <= q_tok.data[7:0];
			sum_s1  <= sum_d;
		end
		if (adv_s2) begin
			kind_s2 <= kind_s1;
			last_s2 <= last_s1;
			byte_s2 <= (kind_s1 == hcgr_pkg::TOK_GRAY) ? prod[35:28] : byte_s1;
		end
		if (load_em) begin
			em_kind_q <= kind_s2;
			em_last_q <= last_s2;
			em_byte_q <= byte_s2;
		end
	end

	always_comb begin
		out_word.out_last = em_last_q;
		out_word.out_byte = em_byte_q;
		if (em_kind_q == hcgr_pkg::TOK_GRAY) begin
			out_word.out_last = em_last_q && (idx_q == 3'd7);
			priority if (idx_q == 3'd0) begin
				out_word.out_byte = hcgr_pkg::CHAR_HASH;
			end else if (idx_q == 3'd7) begin
				out_word.out_byte = hcgr_pkg::CHAR_SEMI;
			end else if (idx_q[0]) begin
				out_word.out_byte = hex_char(em_byte_q[7:4]);
			end else begin
				out_word.out_byte = hex_char(em_byte_q[3:0]);
			end
		end
	end

	assign out_valid = em_valid_q;

	a_pass_single: assert property (@(posedge clk) disable iff (!arst_n)
		(em_valid_q && em_kind_q == hcgr_pkg::TOK_PASS) |-> (idx_q == 3'd0))
		else $error("literal word expanded past one byte");

endmodule

FILE: rtl/hex_color_grayscale_rewriter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_color_grayscale_rewriter
// Rewrites '#rgb;' and '#rrggbb;' colors in a byte stream to the BT.601 gray.
// ----------------------------------------------------------------------------
// input: a word is taken only while the window has no token to push; a '#'
//   is held until 8 bytes are buffered or the last word arrives
// output: 1 word per cycle while out_stall is low; a color expands to 8 words from one queue token
// path: a token passes the queue, stage s1, stage s2 and the emit register
// reset: clears window count, queue and pipeline valids; no clearing pass
module hex_color_grayscale_rewriter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  hcgr_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output hcgr_pkg::out_word_t out_word
);

	logic           push;
	hcgr_pkg::tok_t push_tok;
	logic           q_full;
	logic           q_valid;
	hcgr_pkg::tok_t q_tok;
	logic           pop;

	hcgr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.push     (push),
		.push_tok (push_tok),
		.q_full   (q_full)
	);

	hcgr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_tok    (q_tok),
		.pop      (pop)
	);

	hcgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_tok     (q_tok),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

FILE: tb/sv/hcgr_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcgr_stream_checker
// Watches both channels of the hex color grayscale rewriter, predicts the
// rewritten byte stream from every accepted input word and compares each
// accepted output word with the oldest predicted one.
// ----------------------------------------------------------------------------
module hcgr_stream_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  hcgr_pkg::in_word_t  in_word,
	input  logic                out_valid,
	input  logic                out_stall,
	input  hcgr_pkg::out_word_t out_word,
	output int                  fails,
	output int                  waiting
);

	localparam int LOOKAHEAD = 8;
	localparam int REPORT_MAX = 10;

	logic [7:0]          win [LOOKAHEAD];
	int                  win_cnt = 0;
	hcgr_pkg::out_word_t rewritten_q [$];

	initial begin
		fails = 0;
		waiting = 0;
	end

	function automatic int digit_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return 8'h30 + {4'd0, n};
		return 8'h57 + {4'd0, n};
	endfunction

	function automatic logic [7:0] luma(int r, int g, int b);
		return 8'((299 * r + 587 * g + 114 * b + 500) / 1000);
	endfunction

	// bytes taken by a color at the window front (5 or 8), or 0
	function automatic int color_len(output logic [7:0] y);
		int ch [3];
		int hi;
		int lo;
		y = '0;
		if (win_cnt >= 5 && win[4] == hcgr_pkg::CHAR_SEMI) begin
			for (int i = 0; i < 3; i++) begin
				hi = digit_value(win[1 + i]);
				if (hi < 0) return 0;
				ch[i] = hi * 17;
			end
			y = luma(ch[0], ch[1], ch[2]);
			return 5;
		end
		if (win_cnt >= 8 && win[7] == hcgr_pkg::CHAR_SEMI) begin
			for (int i = 0; i < 3; i++) begin
				hi = digit_value(win[1 + 2 * i]);
				lo = digit_value(win[2 + 2 * i]);
				if (hi < 0 || lo < 0) return 0;
				ch[i] = hi * 16 + lo;
			end
			y = luma(ch[0], ch[1], ch[2]);
			return 8;
		end
		return 0;
	endfunction

	function automatic void put_byte(logic [7:0] b);
		hcgr_pkg::out_word_t w;
		w.out_byte = b;
		w.out_last = 1'b0;
		rewritten_q.push_back(w);
	endfunction

	function automatic void drop_front(int k);
		for (int i = 0; i + k < LOOKAHEAD; i++)
			win[i] = win[i + k];
		win_cnt = (k >= win_cnt) ? 0 : win_cnt - k;
	endfunction

	function automatic void rewrite_step(hcgr_pkg::in_word_t w);
		int         used;
		int         n_before;
		logic [7:0] y;
		n_before = rewritten_q.size();
		win[win_cnt] = w.in_byte;
		win_cnt++;
		while (win_cnt > 0) begin
			if (win[0] != hcgr_pkg::CHAR_HASH) begin
				put_byte(win[0]);
				drop_front(1);
			end else if (win_cnt < LOOKAHEAD && !w.in_last) begin
				break;
			end else begin
				used = color_len(y);
				if (used == 0) begin
					put_byte(win[0]);
					drop_front(1);
				end else begin
					put_byte(hcgr_pkg::CHAR_HASH);
					repeat (3) begin
						put_byte(hex_char(y[7:4]));
						put_byte(hex_char(y[3:0]));
					end
					put_byte(hcgr_pkg::CHAR_SEMI);
					drop_front(used);
				end
			end
		end
		// end of stream marks the final word of this step
		if (w.in_last && rewritten_q.size() > n_before)
			rewritten_q[rewritten_q.size() - 1].out_last = 1'b1;
	endfunction

	always @(posedge clk) begin
		hcgr_pkg::out_word_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				rewrite_step(in_word);
			if (out_valid && !out_stall) begin
				if (rewritten_q.size() == 0) begin
					if (fails < REPORT_MAX)
						$display("[%0t] unexpected word: byte %02h last %0b", $realtime,
							out_word.out_byte, out_word.out_last);
					fails++;
				end else begin
					want = rewritten_q.pop_front();
					if (want.out_byte !== out_word.out_byte
							|| want.out_last !== out_word.out_last) begin
						if (fails < REPORT_MAX)
							$display("[%0t] mismatch: byte exp %02h got %02h, last exp %0b got %0b",
								$realtime, want.out_byte, out_word.out_byte,
								want.out_last, out_word.out_last);
						fails++;
					end
				end
			end
			waiting <= rewritten_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds text streams full of short, long and damaged hex colors into the
// rewriter under random idling on both sides and one long output hold-off;
// the checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT = 26;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	hcgr_pkg::in_word_t  in_word = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	hcgr_pkg::out_word_t out_word;

	int fails;
	int waiting;

	logic sender_idle = 1'b1;
	logic rcv_idle = 1'b1;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   quiet = 0;
	int   sent = 0;

	logic [7:0] stream_q [$];

	hex_color_grayscale_rewriter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	hcgr_stream_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.fails    (fails),
		.waiting  (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= rcv_idle && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_word(logic [7:0] b, logic last);
		while (sender_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= hcgr_pkg::in_word_t'{in_byte: b, in_last: last};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_text(string s, logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], last_at_end && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] rand_hex();
		int v;
		v = int'($urandom_range(0, 21));
		if (v < 10) return 8'(8'h30 + v);
		if (v < 16) return 8'(8'h61 + v - 10);
		return 8'(8'h41 + v - 16);
	endfunction

	// well-formed color, optionally damaged by a stray byte or a lost ';'
	function automatic void add_color(bit long_form, bit damage);
		logic [7:0] seg [$];
		int         pos;
		seg.push_back(hcgr_pkg::CHAR_HASH);
		repeat (long_form ? 6 : 3) seg.push_back(rand_hex());
		seg.push_back(hcgr_pkg::CHAR_SEMI);
		if (damage) begin
			if ($urandom_range(0, 3) == 0) begin
				void'(seg.pop_back());
			end else begin
				pos = int'($urandom_range(1, seg.size() - 1));
				seg[pos] = 8'($urandom_range(0, 255));
			end
		end
		foreach (seg[i]) stream_q.push_back(seg[i]);
	endfunction

	task automatic send_random_stream();
		int pick;
		stream_q.delete();
		repeat ($urandom_range(1, 6)) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 35)
				add_color(1'b0, 1'b0);
			else if (pick < 65)
				add_color(1'b1, 1'b0);
			else if (pick < 80)
				add_color(1'($urandom_range(0, 1)), 1'b1);
			else if (pick < 95)
				stream_q.push_back(8'($urandom_range(0, 255)));
			else
				stream_q.push_back(hcgr_pkg::CHAR_HASH);
		end
		foreach (stream_q[i])
			send_word(stream_q[i], i == stream_q.size() - 1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
		send_text("#fff;", 1'b0);
		send_text("#0aF3c9;", 1'b0);
		// short form whose digit is not hex
		send_text("#1g2;", 1'b0);
		// color cut short by the end of the stream
		send_text("#ab", 1'b1);

		hold_req <= 1'b1;
		while (sent < 130) send_random_stream();
		sender_idle = 1'b0;
		rcv_idle <= 1'b0;
		while (sent < 270) send_random_stream();
		sender_idle = 1'b1;
		rcv_idle <= 1'b1;
		while (sent < 395) send_random_stream();
		in_valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		if (fails == 0 && waiting == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
